[design/svns_pkg.sv]
`timescale 1ns / 1ps
package svns_pkg;

    localparam int VN_W    = 32;
    localparam int SIZE_W  = 16;
    localparam int TAG_W   = 32;
    localparam int WS_W    = 4;
    localparam int DEPTH_W = 9;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_DUP   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [WS_W-1:0] WS_RESET = 4'd4;

    typedef struct packed {
        logic [VN_W-1:0]   vn;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

[design/svns_mem.sv]
`timescale 1ns / 1ps
module svns_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output svns_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  svns_pkg::entry_t      wr_data
);

    svns_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/svns_wmod.sv]
`timescale 1ns / 1ps
module svns_wmod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [svns_pkg::SIZE_W-1:0]   dividend,
    input  logic [svns_pkg::WS_W-1:0]     divisor,
    output logic                          done,
    output logic [svns_pkg::WS_W-1:0]     rem
);

    logic                          active_reg, active_next;
    logic                          done_reg, done_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [svns_pkg::WS_W-1:0]     rem_reg, rem_next;
    logic [svns_pkg::SIZE_W-1:0]   dvd_reg, dvd_next;
    logic [svns_pkg::WS_W-1:0]     dvs_reg, dvs_next;
    logic [svns_pkg::WS_W:0]       trial;

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        trial       = {rem_reg, dvd_reg[cnt_reg]};
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = 4'd15;
            rem_next    = '0;
            dvd_next    = dividend;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
            end
            rem_next = trial[svns_pkg::WS_W-1:0];
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[design/sized_value_number_stack.sv]
`timescale 1ns / 1ps
// Sized value-number stack held in one synchronous memory of STACK_ENTRIES tokens. A command is
// taken when start is high and busy is low, and its single result appears for exactly one cycle
// with done high; the receiver cannot stall it. Push, clear, a pop on an empty stack or with an
// unknown size, and a dup onto an empty stack give their result in the cycle after the transfer.
// An exact pop reads the top token and checks its size. An inexact pop reads and drops whole
// tokens one at a time, then drops or shrinks the top token; a shrink runs the 16-step remainder
// unit and writes the token back. A dup onto a non-empty stack walks down the tokens and then
// copies them one at a time, both through the single memory read port. No clearing pass follows
// reset.
module sized_value_number_stack #(
    parameter int STACK_ENTRIES = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [svns_pkg::VN_W-1:0]       value_number,
    input  logic [svns_pkg::SIZE_W-1:0]     size,
    input  logic                            size_unknown,
    input  logic [svns_pkg::TAG_W-1:0]      line_tag,
    input  logic                            word_size_we,
    input  logic [svns_pkg::WS_W-1:0]       word_size,
    output logic                            done,
    output logic [svns_pkg::VN_W-1:0]       out_value_number,
    output logic [svns_pkg::TAG_W-1:0]      out_line_tag,
    output logic                            out_size_matched,
    output logic [svns_pkg::DEPTH_W-1:0]    depth,
    output logic                            overflow
);

    localparam int AW  = $clog2(STACK_ENTRIES);
    localparam int SPW = $clog2(STACK_ENTRIES + 1);
    localparam logic [SPW-1:0] FULL = SPW'(STACK_ENTRIES);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_POP_CHK = 4'd1;
    localparam logic [3:0] ST_POP_RD  = 4'd2;
    localparam logic [3:0] ST_POP_EV  = 4'd3;
    localparam logic [3:0] ST_POP_TL  = 4'd4;
    localparam logic [3:0] ST_POP_MOD = 4'd5;
    localparam logic [3:0] ST_POP_WR  = 4'd6;
    localparam logic [3:0] ST_DUP_EV  = 4'd7;
    localparam logic [3:0] ST_DUP_RD  = 4'd8;
    localparam logic [3:0] ST_DUP_CP  = 4'd9;

    logic [3:0]                      state_reg, state_next;
    logic [SPW-1:0]                  sp_reg, sp_next;
    logic [svns_pkg::VN_W-1:0]       cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;
    logic [svns_pkg::WS_W-1:0]       ws_reg, ws_next;
    logic                            done_reg, done_next;
    logic [SPW-1:0]                  b_reg, b_next;
    logic [SPW-1:0]                  top_reg, top_next;
    logic [svns_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [svns_pkg::TAG_W-1:0]      tag_reg, tag_next;
    logic [svns_pkg::VN_W-1:0]       ovn_reg, ovn_next;
    logic [svns_pkg::TAG_W-1:0]      otag_reg, otag_next;
    logic                            omatch_reg, omatch_next;

    logic                            mem_rd_en;
    logic [AW-1:0]                   mem_rd_addr;
    svns_pkg::entry_t                mem_rd_data;
    logic                            mem_wr_en;
    logic [AW-1:0]                   mem_wr_addr;
    svns_pkg::entry_t                mem_wr_data;

    logic                            push_req;
    svns_pkg::entry_t                push_data;

    logic                            mod_start;
    logic                            mod_done;
    logic [svns_pkg::WS_W-1:0]       mod_rem;

    logic [svns_pkg::WS_W-1:0]       ws_eff;
    logic [svns_pkg::SIZE_W-1:0]     rsz;
    logic [SPW-1:0]                  sp_m1;
    logic [svns_pkg::SIZE_W:0]       rounded;

    assign ws_eff = (ws_reg == '0) ? svns_pkg::WS_W'(1) : ws_reg;
    assign rsz    = mem_rd_data.size;
    assign sp_m1  = sp_reg - SPW'(1);

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        ws_next     = word_size_we ? word_size : ws_reg;
        done_next   = 1'b0;
        b_next      = b_reg;
        top_next    = top_reg;
        size_next   = size_reg;
        tag_next    = tag_reg;
        ovn_next    = ovn_reg;
        otag_next   = otag_reg;
        omatch_next = omatch_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = sp_m1[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = sp_reg[AW-1:0];
        mem_wr_data = '0;
        push_req    = 1'b0;
        push_data   = '0;
        mod_start   = 1'b0;
        rounded     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    size_next   = size;
                    tag_next    = line_tag;
                    ovn_next    = '0;
                    otag_next   = '0;
                    omatch_next = 1'b0;
                    unique case (func)
                        svns_pkg::FUNC_PUSH:
                        begin
                            if (size_unknown)
                            begin
                                sp_next = '0;
                            end
                            else
                            begin
                                push_req  = 1'b1;
                                push_data = '{vn: value_number, size: size, tag: line_tag};
                            end
                            done_next = 1'b1;
                        end
                        svns_pkg::FUNC_POP:
                        begin
                            if (sp_reg == '0 || size_unknown)
                            begin
                                ovn_next  = cnt_reg;
                                cnt_next  = cnt_reg + svns_pkg::VN_W'(1);
                                sp_next   = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = ST_POP_CHK;
                            end
                        end
                        svns_pkg::FUNC_DUP:
                        begin
                            if (sp_reg == '0)
                            begin
                                push_req  = 1'b1;
                                push_data = '{vn: cnt_reg, size: size, tag: line_tag};
                                cnt_next  = cnt_reg + svns_pkg::VN_W'(1);
                                done_next = 1'b1;
                            end
                            else
                            begin
                                b_next     = sp_m1;
                                top_next   = sp_m1;
                                mem_rd_en  = 1'b1;
                                state_next = ST_DUP_EV;
                            end
                        end
                        default:
                        begin
                            sp_next   = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP_CHK:
            begin
                if (size_reg == rsz)
                begin
                    ovn_next    = mem_rd_data.vn;
                    otag_next   = mem_rd_data.tag;
                    omatch_next = 1'b1;
                    sp_next     = sp_m1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ovn_next = cnt_reg;
                    cnt_next = cnt_reg + svns_pkg::VN_W'(1);
                    if (size_reg > rsz)
                    begin
                        size_next  = size_reg - rsz;
                        sp_next    = sp_m1;
                        state_next = ST_POP_RD;
                    end
                    else
                    begin
                        state_next = ST_POP_TL;
                    end
                end
            end
            ST_POP_RD:
            begin
                if (sp_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_POP_EV;
                end
            end
            ST_POP_EV:
            begin
                if (size_reg >= rsz)
                begin
                    size_next  = size_reg - rsz;
                    sp_next    = sp_m1;
                    state_next = ST_POP_RD;
                end
                else
                begin
                    state_next = ST_POP_TL;
                end
            end
            ST_POP_TL:
            begin
                if ((rsz - size_reg) < {{(svns_pkg::SIZE_W-svns_pkg::WS_W){1'b0}}, ws_eff})
                begin
                    sp_next    = sp_m1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = ST_POP_MOD;
                end
            end
            ST_POP_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_POP_WR;
                end
            end
            ST_POP_WR:
            begin
                rounded = {1'b0, size_reg};
                if (mod_rem != '0)
                begin
                    rounded = rounded + (svns_pkg::SIZE_W+1)'(ws_eff - mod_rem);
                end
                mem_wr_en   = 1'b1;
                mem_wr_addr = sp_m1[AW-1:0];
                mem_wr_data = '{vn: cnt_reg, size: rsz - rounded[svns_pkg::SIZE_W-1:0],
                                tag: mem_rd_data.tag};
                cnt_next    = cnt_reg + svns_pkg::VN_W'(1);
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DUP_EV:
            begin
                if (b_reg != '0 && rsz < size_reg)
                begin
                    size_next   = size_reg - rsz;
                    b_next      = b_reg - SPW'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = b_next[AW-1:0];
                end
                else
                begin
                    if (rsz < size_reg)
                    begin
                        push_req  = 1'b1;
                        push_data = '{vn: cnt_reg, size: size_reg - rsz, tag: tag_reg};
                        cnt_next  = cnt_reg + svns_pkg::VN_W'(1);
                    end
                    else if (rsz > size_reg)
                    begin
                        push_req  = 1'b1;
                        push_data = '{vn: cnt_reg, size: size_reg, tag: tag_reg};
                        cnt_next  = cnt_reg + svns_pkg::VN_W'(1);
                        b_next    = b_reg + SPW'(1);
                    end
                    state_next = ST_DUP_RD;
                end
            end
            ST_DUP_RD:
            begin
                if (b_reg > top_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = b_reg[AW-1:0];
                    state_next  = ST_DUP_CP;
                end
            end
            ST_DUP_CP:
            begin
                push_req   = 1'b1;
                push_data  = '{vn: mem_rd_data.vn, size: rsz, tag: tag_reg};
                b_next     = b_reg + SPW'(1);
                state_next = ST_DUP_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_req)
        begin
            if (sp_reg == FULL)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = sp_reg[AW-1:0];
                mem_wr_data = push_data;
                sp_next     = sp_reg + SPW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ws_reg    <= svns_pkg::WS_RESET;
            done_reg  <= 1'b0;
            b_reg     <= '0;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ws_reg    <= ws_next;
            done_reg  <= done_next;
            b_reg     <= b_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        tag_reg    <= tag_next;
        ovn_reg    <= ovn_next;
        otag_reg   <= otag_next;
        omatch_reg <= omatch_next;
    end

    svns_mem #(
        .DEPTH (STACK_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    svns_wmod u_wmod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (size_reg),
        .divisor  (ws_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign out_value_number = ovn_reg;
    assign out_line_tag     = otag_reg;
    assign out_size_matched = omatch_reg;
    assign depth            = svns_pkg::DEPTH_W'(sp_reg);
    assign overflow         = ovf_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a command is still in progress");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transfer neither in progress nor finished");

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= FULL)
        else $error("stack pointer beyond capacity");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && state_reg != ST_POP_WR) |-> (sp_reg != FULL))
        else $error("push written into a full stack");
`endif

endmodule

[bench/tb_sized_value_number_stack.sv]
`timescale 1ns / 1ps
module tb_sized_value_number_stack;

    localparam int ENTRIES     = 256;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [svns_pkg::VN_W-1:0]    vn;
        logic [svns_pkg::TAG_W-1:0]   tag;
        logic                         matched;
        logic [svns_pkg::DEPTH_W-1:0] depth;
        logic                         overflow;
    } stack_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     func;
    logic [svns_pkg::VN_W-1:0]      value_number;
    logic [svns_pkg::SIZE_W-1:0]    size;
    logic                           size_unknown;
    logic [svns_pkg::TAG_W-1:0]     line_tag;
    logic                           word_size_we;
    logic [svns_pkg::WS_W-1:0]      word_size;
    logic                           done;
    logic [svns_pkg::VN_W-1:0]      out_value_number;
    logic [svns_pkg::TAG_W-1:0]     out_line_tag;
    logic                           out_size_matched;
    logic [svns_pkg::DEPTH_W-1:0]   depth;
    logic                           overflow;

    // Shadow copy of the stack used to predict every result.
    logic [svns_pkg::VN_W-1:0]      tok_vn [ENTRIES];
    logic [svns_pkg::SIZE_W-1:0]    tok_size [ENTRIES];
    logic [svns_pkg::TAG_W-1:0]     tok_tag [ENTRIES];
    int                             tok_count;
    logic [31:0]                    fresh_vn;
    logic                           ovf_seen;
    logic [svns_pkg::WS_W-1:0]      cur_word_size;

    stack_result_t                  pending_results[$];
    int                             error_count;
    int                             idle_pct;
    int                             quiet_cycles;

    sized_value_number_stack #(.STACK_ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .value_number(value_number), .size(size), .size_unknown(size_unknown),
        .line_tag(line_tag), .word_size_we(word_size_we), .word_size(word_size),
        .done(done), .out_value_number(out_value_number), .out_line_tag(out_line_tag),
        .out_size_matched(out_size_matched), .depth(depth), .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] take_fresh_vn();
        logic [31:0] v;
        v = fresh_vn;
        fresh_vn = fresh_vn + 32'd1;
        return v;
    endfunction

    function automatic void add_token(logic [31:0] vn, logic [31:0] sz, logic [31:0] tag);
        if (tok_count >= ENTRIES)
        begin
            ovf_seen = 1'b1;
            return;
        end
        tok_vn[tok_count] = vn;
        tok_size[tok_count] = sz[15:0];
        tok_tag[tok_count] = tag;
        tok_count++;
    endfunction

    function automatic stack_result_t predict_stack_op(logic [1:0] op, logic [31:0] vn,
                                                       logic [15:0] sz_in, logic unk,
                                                       logic [31:0] tag);
        stack_result_t r;
        logic [31:0] sz;
        logic [31:0] ws;
        logic [31:0] tsz;
        logic [31:0] rounded;
        int t;
        int b;
        int top;
        sz = {16'd0, sz_in};
        ws = (cur_word_size == 0) ? 32'd1 : {28'd0, cur_word_size};
        r.vn = '0;
        r.tag = '0;
        r.matched = 1'b0;
        if (op == svns_pkg::FUNC_PUSH)
        begin
            if (unk)
                tok_count = 0;
            else
                add_token(vn, sz, tag);
        end
        else if (op == svns_pkg::FUNC_POP)
        begin
            if (!unk && tok_count > 0 && sz == {16'd0, tok_size[tok_count-1]})
            begin
                r.vn = tok_vn[tok_count-1];
                r.tag = tok_tag[tok_count-1];
                r.matched = 1'b1;
                tok_count--;
            end
            else
            begin
                r.vn = take_fresh_vn();
                if (tok_count > 0)
                begin
                    if (unk)
                        tok_count = 0;
                    else
                    begin
                        if (sz > {16'd0, tok_size[tok_count-1]})
                            while (tok_count > 0 && sz >= {16'd0, tok_size[tok_count-1]})
                            begin
                                sz = sz - {16'd0, tok_size[tok_count-1]};
                                tok_count--;
                            end
                        if (tok_count > 0)
                        begin
                            t = tok_count - 1;
                            tsz = {16'd0, tok_size[t]};
                            if (tsz - sz < ws)
                                tok_count--;
                            else
                            begin
                                rounded = (sz / ws) * ws + (((sz % ws) != 0) ? ws : 32'd0);
                                tok_vn[t] = take_fresh_vn();
                                tok_size[t] = tsz[15:0] - rounded[15:0];
                            end
                        end
                    end
                end
            end
        end
        else if (op == svns_pkg::FUNC_DUP)
        begin
            if (tok_count == 0)
                add_token(take_fresh_vn(), sz, tag);
            else
            begin
                top = tok_count - 1;
                b = top;
                while (b > 0 && {16'd0, tok_size[b]} < sz)
                begin
                    sz = sz - {16'd0, tok_size[b]};
                    b--;
                end
                if ({16'd0, tok_size[b]} < sz)
                    add_token(take_fresh_vn(), sz - {16'd0, tok_size[b]}, tag);
                else if ({16'd0, tok_size[b]} > sz)
                begin
                    add_token(take_fresh_vn(), sz, tag);
                    b++;
                end
                while (b <= top)
                begin
                    add_token(tok_vn[b], {16'd0, tok_size[b]}, tag);
                    b++;
                end
            end
        end
        else
            tok_count = 0;
        r.depth = tok_count[svns_pkg::DEPTH_W-1:0];
        r.overflow = ovf_seen;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, depth", {23'd0, depth}, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_value_number !== want.vn)
                    report_mismatch("out_value_number", out_value_number, want.vn);
                if (out_line_tag !== want.tag)
                    report_mismatch("out_line_tag", out_line_tag, want.tag);
                if (out_size_matched !== want.matched)
                    report_mismatch("out_size_matched", {31'd0, out_size_matched},
                                    {31'd0, want.matched});
                if (depth !== want.depth)
                    report_mismatch("depth", {23'd0, depth}, {23'd0, want.depth});
                if (overflow !== want.overflow)
                    report_mismatch("overflow", {31'd0, overflow}, {31'd0, want.overflow});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_op(logic [1:0] op, logic [31:0] vn, logic [15:0] sz, logic unk,
                           logic [31:0] tag);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        func = op;
        value_number = vn;
        size = sz;
        size_unknown = unk;
        line_tag = tag;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_stack_op(op, vn, sz, unk, tag));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_word_size(logic [svns_pkg::WS_W-1:0] ws);
        wait_drained();
        word_size = ws;
        word_size_we = 1'b1;
        @(negedge clk);
        word_size_we = 1'b0;
        cur_word_size = ws;
    endtask

    task automatic test_directed();
        send_op(svns_pkg::FUNC_POP, 32'h1, 16'd4, 1'b0, 32'h2);
        send_op(svns_pkg::FUNC_PUSH, 32'h0, 16'd0, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'hFFFF, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd0, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, 32'hA5A5_5A5A, 16'd8, 1'b0, 32'h1234);
        send_op(svns_pkg::FUNC_PUSH, 32'h5A5A_A5A5, 16'd12, 1'b0, 32'h5678);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd3, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd10, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, 32'h77, 16'd4, 1'b0, 32'h9);
        send_op(svns_pkg::FUNC_PUSH, 32'h88, 16'd4, 1'b0, 32'hA);
        send_op(svns_pkg::FUNC_DUP, 32'h0, 16'd8, 1'b0, 32'hBEEF);
        send_op(svns_pkg::FUNC_DUP, 32'h0, 16'd6, 1'b0, 32'hCAFE);
        send_op(svns_pkg::FUNC_DUP, 32'h0, 16'd200, 1'b1, 32'hD00D);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd5, 1'b1, 32'h0);
        send_op(svns_pkg::FUNC_DUP, 32'h0, 16'd16, 1'b0, 32'h1);
        send_op(svns_pkg::FUNC_PUSH, 32'h99, 16'd3, 1'b1, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, 32'h11, 16'd20, 1'b0, 32'h3);
        send_op(svns_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd1, 1'b1, 32'h0);
    endtask

    task automatic test_word_size_extremes();
        logic [svns_pkg::WS_W-1:0] sweep [4];
        sweep = '{4'd1, 4'd8, 4'd0, 4'd15};
        foreach (sweep[i])
        begin
            set_word_size(sweep[i]);
            send_op(svns_pkg::FUNC_PUSH, $urandom, 16'd40, 1'b0, $urandom);
            send_op(svns_pkg::FUNC_POP, 32'h0, 16'd3, 1'b0, 32'h0);
            send_op(svns_pkg::FUNC_POP, 32'h0, 16'd9, 1'b0, 32'h0);
            send_op(svns_pkg::FUNC_CLEAR, 32'h0, 16'd0, 1'b0, 32'h0);
        end
    endtask

    task automatic test_random(int count);
        logic [1:0]  op;
        logic [15:0] sz;
        logic        unk;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            unk = ($urandom_range(99) < 4);
            if (tok_count > 48 && pick < 60)
                pick = 60;
            if (pick < 45)
                op = svns_pkg::FUNC_PUSH;
            else if (pick < 80)
                op = svns_pkg::FUNC_POP;
            else if (pick < 96)
                op = svns_pkg::FUNC_DUP;
            else
                op = svns_pkg::FUNC_CLEAR;
            pick = $urandom_range(99);
            if (op == svns_pkg::FUNC_POP && tok_count > 0 && pick < 45)
                sz = tok_size[tok_count-1];
            else if (pick < 90)
                sz = (op == svns_pkg::FUNC_DUP) ? 16'($urandom_range(30))
                                                : 16'($urandom_range(20));
            else
                sz = 16'($urandom);
            if ($urandom_range(199) == 0)
                wait_drained();
            send_op(op, $urandom, sz, unk, ($urandom_range(9) == 0) ? 32'h0 : $urandom);
        end
    endtask

    task automatic test_overflow();
        wait_drained();
        send_op(svns_pkg::FUNC_CLEAR, 32'h0, 16'd0, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, $urandom, 16'd1, 1'b0, $urandom);
        for (int k = 1; k <= 128; k = k * 2)
            send_op(svns_pkg::FUNC_DUP, 32'h0, k[15:0], 1'b0, $urandom);
        send_op(svns_pkg::FUNC_PUSH, $urandom, 16'd2, 1'b0, $urandom);
        send_op(svns_pkg::FUNC_DUP, 32'h0, 16'd3, 1'b0, $urandom);
        send_op(svns_pkg::FUNC_POP, 32'h0, 16'd1, 1'b0, 32'h0);
        send_op(svns_pkg::FUNC_PUSH, $urandom, 16'd5, 1'b0, $urandom);
        send_op(svns_pkg::FUNC_CLEAR, 32'h0, 16'd0, 1'b0, 32'h0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = svns_pkg::FUNC_PUSH;
        value_number = '0;
        size = '0;
        size_unknown = 1'b0;
        line_tag = '0;
        word_size_we = 1'b0;
        word_size = svns_pkg::WS_RESET;
        tok_count = 0;
        fresh_vn = '0;
        ovf_seen = 1'b0;
        cur_word_size = svns_pkg::WS_RESET;
        error_count = 0;
        idle_pct = 28;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_word_size_extremes();
        set_word_size(4'($urandom_range(8, 1)));
        test_random(400);
        idle_pct = 58;
        set_word_size(4'($urandom_range(8, 1)));
        test_random(400);
        idle_pct = 0;
        set_word_size(4'd8);
        test_random(250);
        test_overflow();
        set_word_size(4'd1);
        test_random(150);

        wait_drained();
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
